FILE: rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared constants, codes and types of the positional circular list core.
// ----------------------------------------------------------------------------
package pcl_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;
   localparam int ACT_W    = 2;
   localparam int STS_W    = 2;
   // width that holds a position or a count plus one without overflow
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SEARCH = 2'd2
   } action_type;

   typedef enum logic [STS_W-1:0] {
      ST_DONE = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

FILE: rtl/pcl_ifs.sv
// ----------------------------------------------------------------------------
// pcl_ifs
// Valid/ready channels of the list core: request and response.
// ----------------------------------------------------------------------------
interface pcl_req_if import pcl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        action;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);
endinterface

interface pcl_rsp_if import pcl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [STS_W-1:0] status;
   logic             found;
   logic [CNT_W-1:0] count;

   modport source (output valid, output status, output found, output count,
                   input ready);
   modport sink   (input valid, input status, input found, input count,
                   output ready);
endinterface

FILE: rtl/pcl_ram.sv
// ----------------------------------------------------------------------------
// pcl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/pcl_ctrl.sv
// ----------------------------------------------------------------------------
// pcl_ctrl
// Request sequencer: shifts, scans and checks the stored list through the
// element RAM, keeps the element count and holds the response register.
// ----------------------------------------------------------------------------
module pcl_ctrl import pcl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pcl_req_if.sink          req,
   pcl_rsp_if.source        rsp,
   output logic             mem_we,
   output logic [IDX_W-1:0] mem_waddr,
   output logic [VAL_W-1:0] mem_wdata,
   output logic             mem_re,
   output logic [IDX_W-1:0] mem_raddr,
   input  logic [VAL_W-1:0] mem_rdata
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] pos0_ff, pos0_in;
   logic             pending_ff, pending_in;
   logic [VAL_W-1:0] val_ff, val_in;
   status_type       status_ff, status_in;
   logic             found_ff, found_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;

   assign pos_x = CMP_W'(req.position);
   assign cnt_x = CMP_W'(cnt_ff);

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.found  = rsp_found_ff;
   assign rsp.count  = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      wr_ff         <= wr_in;
      pos0_ff       <= pos0_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      wr_in         = wr_ff;
      pos0_in       = pos0_ff;
      pending_in    = 1'b0;
      val_in        = val_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ff;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = cur_ff[IDX_W-1:0];

      // a read issued last cycle lands now: write it to its shifted place
      if (pending_ff && (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DN)) begin
         mem_we = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               val_in    = req.value;
               pos0_in   = IDX_W'(req.position - POS_W'(1));
               found_in  = 1'b0;
               status_in = ST_DONE;
               case (req.action)
                  ACT_INSERT: begin
                     if (cnt_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_FINISH;
                     end else if (req.position == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                        status_in = ST_BAD;
                        state_in  = S_FINISH;
                     end else begin
                        cur_in   = cnt_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  ACT_DELETE: begin
                     if (req.position == '0 || pos_x > cnt_x) begin
                        status_in = ST_BAD;
                        state_in  = S_FINISH;
                     end else begin
                        cur_in   = CNT_W'(req.position - POS_W'(1));
                        state_in = S_SHIFT_DN;
                     end
                  end
                  ACT_SEARCH: begin
                     cur_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     status_in = ST_BAD;
                     state_in  = S_FINISH;
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // walk down from the tail, moving each element one place up
            if (cur_ff > CNT_W'(pos0_ff)) begin
               mem_re     = 1'b1;
               mem_raddr  = IDX_W'(cur_ff - CNT_W'(1));
               wr_in      = cur_ff[IDX_W-1:0];
               cur_in     = cur_ff - CNT_W'(1);
               pending_in = 1'b1;
            end else if (!pending_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos0_ff;
               mem_wdata = val_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
               state_in  = S_FINISH;
            end
         end

         S_SHIFT_DN: begin
            // walk up from the hole, moving each element one place down
            if (cur_ff + CNT_W'(1) < cnt_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = IDX_W'(cur_ff + CNT_W'(1));
               wr_in      = cur_ff[IDX_W-1:0];
               cur_in     = cur_ff + CNT_W'(1);
               pending_in = 1'b1;
            end else if (!pending_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end

         S_SCAN: begin
            if (pending_ff && mem_rdata == val_ff) begin
               found_in = 1'b1;
            end
            if (cur_ff < cnt_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = cur_ff[IDX_W-1:0];
               cur_in     = cur_ff + CNT_W'(1);
               pending_in = 1'b1;
            end else if (!pending_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // load the response once the previous one has been transferred
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same entry in one cycle");

   a_pending_tracks_read: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> pending_ff)
      else $error("issued read not marked pending");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_waddr) <= cnt_ff))
      else $error("write beyond the list tail");
`endif

endmodule

FILE: rtl/positional_circular_list_core.sv
// ----------------------------------------------------------------------------
// positional_circular_list_core
// Bounded ordered list of signed 32-bit values with insert and delete by
// position and search by value, held in a single element RAM.
//
//   channel  | dir | payload
//   ---------+-----+----------------------------------
//   req_chan | in  | action, position, value
//   rsp_chan | out | status, found, count
//
// One request at a time: ready is low from the accept until the sequencer
// returns to idle. The element RAM's single read port moves one element per
// cycle, and the last read lands before the request finishes.
// Reset empties the list; the RAM needs no clearing pass.
// A new request is taken while the previous response still waits; a stalled
// response holds the sequencer only at the end of the next request.
// ----------------------------------------------------------------------------
module positional_circular_list_core import pcl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pcl_req_if.sink   req_chan,
   pcl_rsp_if.source rsp_chan
);

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [VAL_W-1:0] mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic [VAL_W-1:0] mem_rdata;

   pcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   pcl_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule
